@@ rtl/sll_pkg.sv @@
// Shared types and constants for the static linked list engine.
// Depends on nothing; imported by the top level.
package sll_pkg;

    localparam int POS_W  = 10;
    localparam int DATA_W = 32;

    // Request codes carried on the req_type field.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_INS_K,
        ST_INS_POP,
        ST_WALK,
        ST_WEND,
        ST_INS_LINK,
        ST_DEL_UNLINK,
        ST_DEL_FREE,
        ST_DEL_PUSH,
        ST_DONE
    } t_state;

endpackage

@@ rtl/sll_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stand-alone; used for the link store and the value store of the list engine.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/static_linked_list_engine.sv @@
// Static linked list engine: SLOTS entries of link and value, slot 0 heading the free
// list and slot SLOTS-1 heading the data list. After reset the block runs a clearing pass
// that rebuilds the free chain and accepts no word meanwhile. The time that a request at
// position p takes from acceptance until the block is ready again is set by the walk
// along the links, one link per cycle through the one read port of the link RAM, plus
// read-modify-write steps on the free and data lists; a rejected request skips both. One
// request is handled at a time, and a finished result waits in the output register
// while the next request is taken.
module static_linked_list_engine #(
    parameter int SLOTS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic [sll_pkg::POS_W-1:0]          i_position,
    input  logic signed [sll_pkg::DATA_W-1:0]  i_data_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_ok,
    output logic signed [sll_pkg::DATA_W-1:0]  o_data_out,
    output logic [sll_pkg::POS_W-1:0]          o_list_length
);

    import sll_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam logic [AW-1:0] HEAD = AW'(SLOTS - 1);
    localparam logic [AW-1:0] FREE_HEAD = '0;

    t_state r_state, n_state;
    logic [AW-1:0]     r_init, n_init;
    logic [AW-1:0]     r_count, n_count;
    logic              r_out_valid, n_out_valid;

    logic              r_req;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_din;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_j, n_j;
    logic [POS_W-1:0]  r_left, n_left;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_dout, n_dout;
    logic              r_o_ok;
    logic [DATA_W-1:0] r_o_dout;
    logic [POS_W-1:0]  r_o_len;

    logic              lk_we, lk_re;
    logic [AW-1:0]     lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic              vs_we, vs_re;
    logic [AW-1:0]     vs_raddr;
    logic [DATA_W-1:0] vs_rdata;

    logic              accept, out_load;
    logic [CW-1:0]     pos_x, cnt_x;
    logic              ins_ok, del_ok;

    sll_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    sll_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vs_we),
        .i_waddr (r_k),
        .i_wdata (r_din),
        .i_re    (vs_re),
        .i_raddr (vs_raddr),
        .o_rdata (vs_rdata)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    assign pos_x  = CW'(i_position);
    assign cnt_x  = CW'(r_count);
    assign ins_ok = (cnt_x < CW'(SLOTS - 2)) && (i_position != '0) && (pos_x <= cnt_x + 1'b1);
    assign del_ok = (r_count != '0) && (i_position != '0) && (pos_x <= cnt_x);

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_count     = r_count;
        n_k         = r_k;
        n_j         = r_j;
        n_left      = r_left;
        n_ok        = r_ok;
        n_dout      = r_dout;
        n_out_valid = r_out_valid;
        lk_we       = 1'b0;
        lk_waddr    = FREE_HEAD;
        lk_wdata    = '0;
        lk_re       = 1'b0;
        lk_raddr    = FREE_HEAD;
        vs_we       = 1'b0;
        vs_re       = 1'b0;
        vs_raddr    = r_k;

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_INIT: begin
                // Rebuild the free chain: every slot links to the next, the last to none.
                lk_we    = 1'b1;
                lk_waddr = r_init;
                lk_wdata = (r_init == HEAD) ? '0 : r_init + 1'b1;
                n_init   = r_init + 1'b1;
                if (r_init == HEAD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_ok   = 1'b0;
                    n_dout = '0;
                    if (i_req_type == REQ_INSERT && ins_ok) begin
                        lk_re    = 1'b1;
                        lk_raddr = FREE_HEAD;
                        n_state  = ST_INS_K;
                    end else if (i_req_type == REQ_DELETE && del_ok) begin
                        lk_re    = 1'b1;
                        lk_raddr = HEAD;
                        n_j      = HEAD;
                        n_left   = i_position - 1'b1;
                        n_state  = (i_position == POS_W'(1)) ? ST_WEND : ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_INS_K: begin
                // The free head arrives; fetch its successor to pop it.
                n_k      = lk_rdata;
                lk_re    = 1'b1;
                lk_raddr = lk_rdata;
                n_state  = ST_INS_POP;
            end
            ST_INS_POP: begin
                lk_we    = 1'b1;
                lk_waddr = FREE_HEAD;
                lk_wdata = lk_rdata;
                vs_we    = 1'b1;
                lk_re    = 1'b1;
                lk_raddr = HEAD;
                n_j      = HEAD;
                n_left   = r_pos - 1'b1;
                n_state  = (r_pos == POS_W'(1)) ? ST_WEND : ST_WALK;
            end
            ST_WALK: begin
                // Each cycle follows one link; the address just read becomes the node.
                lk_re    = 1'b1;
                lk_raddr = lk_rdata;
                n_j      = lk_rdata;
                n_left   = r_left - 1'b1;
                if (r_left == POS_W'(1)) begin
                    n_state = ST_WEND;
                end
            end
            ST_WEND: begin
                if (r_req == REQ_INSERT) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_k;
                    lk_wdata = lk_rdata;
                    n_state  = ST_INS_LINK;
                end else begin
                    n_k      = lk_rdata;
                    lk_re    = 1'b1;
                    lk_raddr = lk_rdata;
                    vs_re    = 1'b1;
                    vs_raddr = lk_rdata;
                    n_state  = ST_DEL_UNLINK;
                end
            end
            ST_INS_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_j;
                lk_wdata = r_k;
                n_count  = r_count + 1'b1;
                n_ok     = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DEL_UNLINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_j;
                lk_wdata = lk_rdata;
                n_dout   = vs_rdata;
                lk_re    = 1'b1;
                lk_raddr = FREE_HEAD;
                n_state  = ST_DEL_FREE;
            end
            ST_DEL_FREE: begin
                lk_we    = 1'b1;
                lk_waddr = r_k;
                lk_wdata = lk_rdata;
                n_state  = ST_DEL_PUSH;
            end
            ST_DEL_PUSH: begin
                lk_we    = 1'b1;
                lk_waddr = FREE_HEAD;
                lk_wdata = r_k;
                n_count  = r_count - 1'b1;
                n_ok     = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_din <= i_data_in;
        end
        r_k    <= n_k;
        r_j    <= n_j;
        r_left <= n_left;
        r_ok   <= n_ok;
        r_dout <= n_dout;
        if (out_load) begin
            r_o_ok   <= r_ok;
            r_o_dout <= r_dout;
            r_o_len  <= cnt_x[POS_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_o_ok;
    assign o_data_out    = r_o_dout;
    assign o_list_length = r_o_len;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(SLOTS - 2))
        else $error("element count above capacity");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_left != '0))
        else $error("walk entered with no links left to follow");

    a_slot_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_LINK) |-> (r_k != FREE_HEAD && r_k != HEAD))
        else $error("insert took a list head as storage");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lk_we && lk_re) |-> (lk_waddr != lk_raddr))
        else $error("link RAM read and written at the same entry");

    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && r_state == ST_IDLE))
        else $error("finished word not presented at the output");

endmodule
